// ===== rtl/lcdq_pkg.sv =====
// Shared types and constants for the character-LCD write queue sequencer.
`timescale 1ns / 1ps

package lcdq_pkg;

    // Kind of a request after classification in the front end
    typedef enum logic {
        ITEM_TICK = 1'b0,
        ITEM_CHAR = 1'b1
    } item_kind_t;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_COLUMN = 2'd1,
        STATUS_ROW    = 2'd2,
        STATUS_FULL   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        REG_FUNCTION_SET   = 2'd0,
        REG_DISPLAY_CTRL   = 2'd1,
        REG_FIRST_LINE     = 2'd2,
        REG_SECOND_LINE    = 2'd3
    } cfg_index_t;

    // Classified request travelling from front end to back end
    typedef struct packed {
        item_kind_t  kind;
        logic [7:0]  character;
        logic [5:0]  column;
        logic [1:0]  row;
        logic        is_last;
        logic        col_err;
        logic        row_err;
    } q_item_t;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    localparam logic [7:0] CMD_CLEAR       = 8'h01;
    localparam logic [7:0] CMD_HOME        = 8'h02;
    localparam logic [7:0] CMD_DDRAM_START = 8'h80;

    localparam logic [7:0] RST_FUNCTION_SET = 8'd56;
    localparam logic [7:0] RST_DISPLAY_CTRL = 8'd15;
    localparam logic [7:0] RST_FIRST_LINE   = 8'd128;
    localparam logic [7:0] RST_SECOND_LINE  = 8'd192;

endpackage

// ===== rtl/lcdq_front.sv =====
// Front end: classifies incoming requests and holds them in a short queue.
`timescale 1ns / 1ps

module lcdq_front #(
    parameter int COLUMNS = 16,
    parameter int ROWS    = 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_operation,
    input  logic [7:0]        s_character,
    input  logic [5:0]        s_column,
    input  logic [1:0]        s_row,
    input  logic              s_is_last,
    output logic              q_valid,
    output lcdq_pkg::q_item_t q_item,
    input  logic              q_pop
);

    localparam logic [6:0] COL_LIMIT = 7'(COLUMNS);
    localparam logic [2:0] ROW_LIMIT = 3'(ROWS);

    lcdq_pkg::q_item_t                     in_item;
    lcdq_pkg::q_item_t                     queue_reg [lcdq_pkg::QUEUE_DEPTH];
    logic [lcdq_pkg::QUEUE_PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [lcdq_pkg::QUEUE_PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [lcdq_pkg::QUEUE_CNT_W-1:0]      count_reg, count_next;
    logic                                  push;

    always_comb begin
        in_item.kind      = s_operation ? lcdq_pkg::ITEM_CHAR : lcdq_pkg::ITEM_TICK;
        in_item.character = s_character;
        in_item.column    = s_column;
        in_item.row       = s_row;
        in_item.is_last   = s_is_last;
        in_item.col_err   = {1'b0, s_column} >= COL_LIMIT;
        in_item.row_err   = {1'b0, s_row} >= ROW_LIMIT;
    end

    assign s_ready = count_reg != lcdq_pkg::QUEUE_CNT_W'(lcdq_pkg::QUEUE_DEPTH);
    assign push    = s_valid && s_ready;
    assign q_valid = count_reg != '0;
    assign q_item  = queue_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && q_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== rtl/lcdq_back.sv =====
// Back end: init sequencer, slot store, string sender and result register.
`timescale 1ns / 1ps

module lcdq_back #(
    parameter int SLOTS     = 4,
    parameter int MAX_CHARS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wen,
    input  logic [1:0]        cfg_index,
    input  logic [7:0]        cfg_wdata,
    input  logic              q_valid,
    input  lcdq_pkg::q_item_t q_item,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_status,
    output logic              m_enable_pin,
    output logic              m_register_select,
    output logic [7:0]        m_data_bus,
    output logic              m_busy_res
);

    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PW    = $clog2(MAX_CHARS + 1);
    localparam int DEPTH = SLOTS * MAX_CHARS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PW-1:0] MAX_LEN = PW'(MAX_CHARS);

    typedef enum logic [6:0] {
        INIT_START = 7'b0000001,
        INIT_FUNC  = 7'b0000010,
        INIT_CLEAR = 7'b0000100,
        INIT_HOME  = 7'b0001000,
        INIT_DISP  = 7'b0010000,
        INIT_DDRAM = 7'b0100000,
        INIT_DONE  = 7'b1000000
    } init_phase_t;

    typedef enum logic [3:0] {
        WR_START    = 4'b0001,
        WR_POSITION = 4'b0010,
        WR_CHARS    = 4'b0100,
        WR_DONE     = 4'b1000
    } write_phase_t;

    function automatic logic [SW-1:0] lowest_set(input logic [SLOTS-1:0] vec);
        logic [SW-1:0] idx;
        idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (vec[i]) begin
                idx = SW'(i);
            end
        end
        return idx;
    endfunction

    // configuration
    logic [7:0] function_set_reg, display_ctrl_reg, first_line_reg, second_line_reg;

    // sequencer state
    init_phase_t  init_phase_reg, init_phase_next, init_advance;
    write_phase_t write_phase_reg, write_phase_next;
    logic              en_reg, en_next;
    logic              rs_reg, rs_next;
    logic [7:0]        data_reg, data_next;
    logic              busy_reg, busy_next;
    logic              request_active_reg, request_active_next;
    logic [SW-1:0]     current_slot_reg, current_slot_next;
    logic [PW-1:0]     char_position_reg, char_position_next;
    logic [SLOTS-1:0]  slot_pending_reg, slot_pending_next;
    logic [SW-1:0]     fill_slot_reg, fill_slot_next;
    logic              fill_active_reg, fill_active_next;
    logic [PW-1:0]     fill_len_reg, fill_len_next;
    logic [5:0]        slot_column_reg [SLOTS];
    logic [5:0]        slot_column_next [SLOTS];
    logic              slot_row_reg [SLOTS];
    logic              slot_row_next [SLOTS];
    logic [PW-1:0]     slot_length_reg [SLOTS];
    logic [PW-1:0]     slot_length_next [SLOTS];

    // result register
    logic                  m_valid_reg, m_valid_next;
    lcdq_pkg::status_t     m_status_reg, m_status_next;

    // text store
    logic [7:0]        text_mem [DEPTH];
    logic [7:0]        rd_data_reg;
    logic              rd_ok_reg;
    logic [AW-1:0]     rd_addr, mem_waddr;
    logic              mem_we;

    // helpers
    logic [7:0]        init_cmd;
    logic [7:0]        line_base;
    logic [PW-1:0]     cur_length;
    logic              char_in_range, chars_drive, out_free, back_fire;
    logic              free_any, pend_any, done_any;
    logic [SW-1:0]     free_idx, pend_idx, done_idx;
    logic [SLOTS-1:0]  done_mask;
    logic              accept;
    logic [SW-1:0]     acc_slot;
    logic [PW-1:0]     acc_len, acc_len_new;

    assign cur_length    = slot_length_reg[current_slot_reg];
    assign char_in_range = (char_position_reg < cur_length) && (char_position_reg < MAX_LEN);
    assign line_base     = slot_row_reg[current_slot_reg] ? second_line_reg : first_line_reg;
    assign rd_addr       = AW'(32'(current_slot_reg) * 32'(MAX_CHARS) + 32'(char_position_reg));

    assign free_any = ~&slot_pending_reg;
    assign free_idx = lowest_set(~slot_pending_reg);
    assign pend_any = |slot_pending_reg;
    assign pend_idx = lowest_set(slot_pending_reg);

    always_comb begin
        done_mask                   = slot_pending_reg;
        done_mask[current_slot_reg] = 1'b0;
    end
    assign done_any = |done_mask;
    assign done_idx = lowest_set(done_mask);

    always_comb begin
        unique case (init_phase_reg)
            INIT_FUNC:  init_cmd = function_set_reg;
            INIT_CLEAR: init_cmd = lcdq_pkg::CMD_CLEAR;
            INIT_HOME:  init_cmd = lcdq_pkg::CMD_HOME;
            INIT_DISP:  init_cmd = display_ctrl_reg;
            default:    init_cmd = lcdq_pkg::CMD_DDRAM_START;
        endcase
        unique case (init_phase_reg)
            INIT_START: init_advance = INIT_FUNC;
            INIT_FUNC:  init_advance = INIT_CLEAR;
            INIT_CLEAR: init_advance = INIT_HOME;
            INIT_HOME:  init_advance = INIT_DISP;
            INIT_DISP:  init_advance = INIT_DDRAM;
            default:    init_advance = INIT_DONE;
        endcase
    end

    // A tick that puts a stored character on the bus needs the registered text
    // read of the current address; that data is good only if no request was
    // executed in the previous cycle.
    assign chars_drive = (q_item.kind == lcdq_pkg::ITEM_TICK) && (init_phase_reg == INIT_DONE)
                       && request_active_reg && (write_phase_reg == WR_CHARS)
                       && char_in_range && !en_reg;
    assign out_free  = !m_valid_reg || m_ready;
    assign back_fire = q_valid && out_free && !(chars_drive && !rd_ok_reg);
    assign q_pop     = back_fire;

    always_comb begin
        init_phase_next     = init_phase_reg;
        write_phase_next    = write_phase_reg;
        en_next             = en_reg;
        rs_next             = rs_reg;
        data_next           = data_reg;
        busy_next           = busy_reg;
        request_active_next = request_active_reg;
        current_slot_next   = current_slot_reg;
        char_position_next  = char_position_reg;
        slot_pending_next   = slot_pending_reg;
        fill_slot_next      = fill_slot_reg;
        fill_active_next    = fill_active_reg;
        fill_len_next       = fill_len_reg;
        slot_column_next    = slot_column_reg;
        slot_row_next       = slot_row_reg;
        slot_length_next    = slot_length_reg;
        m_status_next       = m_status_reg;
        mem_we              = 1'b0;
        accept              = 1'b0;
        acc_slot            = fill_slot_reg;
        acc_len             = fill_len_reg;
        acc_len_new         = fill_len_reg;
        mem_waddr           = '0;

        if (back_fire) begin
            m_status_next = lcdq_pkg::STATUS_OK;
            unique case (q_item.kind)
                lcdq_pkg::ITEM_CHAR: begin
                    accept = 1'b1;
                    if (!fill_active_reg) begin
                        // only the first character of a request is checked
                        priority if (q_item.col_err) begin
                            m_status_next = lcdq_pkg::STATUS_COLUMN;
                            accept        = 1'b0;
                        end else if (q_item.row_err) begin
                            m_status_next = lcdq_pkg::STATUS_ROW;
                            accept        = 1'b0;
                        end else if (!free_any) begin
                            m_status_next = lcdq_pkg::STATUS_FULL;
                            accept        = 1'b0;
                        end else begin
                            acc_slot                   = free_idx;
                            acc_len                    = '0;
                            slot_column_next[free_idx] = q_item.column;
                            slot_row_next[free_idx]    = q_item.row[0];
                        end
                    end
                    acc_len_new = acc_len;
                    if (accept) begin
                        if (acc_len < MAX_LEN) begin
                            mem_we      = 1'b1;
                            mem_waddr   = AW'(32'(acc_slot) * 32'(MAX_CHARS) + 32'(acc_len));
                            acc_len_new = acc_len + PW'(1);
                        end
                        slot_length_next[acc_slot] = acc_len_new;
                        fill_len_next              = acc_len_new;
                        fill_slot_next             = acc_slot;
                        if (q_item.is_last) begin
                            slot_pending_next[acc_slot] = 1'b1;
                            fill_active_next            = 1'b0;
                            if (!request_active_reg) begin
                                request_active_next = 1'b1;
                                write_phase_next    = WR_START;
                            end
                        end else begin
                            fill_active_next = 1'b1;
                        end
                    end
                end
                lcdq_pkg::ITEM_TICK: begin
                    if (init_phase_reg != INIT_DONE) begin
                        if (init_phase_reg == INIT_START) begin
                            en_next         = 1'b0;
                            init_phase_next = INIT_FUNC;
                        end else if (!en_reg) begin
                            en_next   = 1'b1;
                            rs_next   = 1'b0;
                            data_next = init_cmd;
                        end else begin
                            en_next         = 1'b0;
                            init_phase_next = init_advance;
                            if (init_advance == INIT_DONE) begin
                                busy_next = 1'b0;
                            end
                        end
                    end else if (request_active_reg) begin
                        unique case (write_phase_reg)
                            WR_START: begin
                                busy_next = 1'b1;
                                if (!pend_any) begin
                                    request_active_next = 1'b0;
                                    current_slot_next   = '0;
                                    busy_next           = 1'b0;
                                end else begin
                                    current_slot_next  = pend_idx;
                                    char_position_next = '0;
                                    write_phase_next   = WR_POSITION;
                                end
                            end
                            WR_POSITION: begin
                                busy_next = 1'b1;
                                if (!en_reg) begin
                                    en_next   = 1'b1;
                                    rs_next   = 1'b0;
                                    data_next = line_base
                                              + {2'b00, slot_column_reg[current_slot_reg]};
                                end else begin
                                    en_next          = 1'b0;
                                    write_phase_next = WR_CHARS;
                                end
                            end
                            WR_CHARS: begin
                                if (char_in_range) begin
                                    if (!en_reg) begin
                                        en_next   = 1'b1;
                                        rs_next   = 1'b1;
                                        data_next = rd_data_reg;
                                    end else begin
                                        en_next            = 1'b0;
                                        char_position_next = char_position_reg + PW'(1);
                                    end
                                end else begin
                                    write_phase_next = WR_DONE;
                                end
                            end
                            WR_DONE: begin
                                slot_pending_next[current_slot_reg] = 1'b0;
                                if (!done_any) begin
                                    request_active_next = 1'b0;
                                    current_slot_next   = '0;
                                    busy_next           = 1'b0;
                                end else begin
                                    current_slot_next = done_idx;
                                end
                                write_phase_next = WR_START;
                            end
                            default: begin
                                write_phase_next = WR_START;
                            end
                        endcase
                    end
                end
            endcase
        end

        if (back_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            function_set_reg <= lcdq_pkg::RST_FUNCTION_SET;
            display_ctrl_reg <= lcdq_pkg::RST_DISPLAY_CTRL;
            first_line_reg   <= lcdq_pkg::RST_FIRST_LINE;
            second_line_reg  <= lcdq_pkg::RST_SECOND_LINE;
        end else if (cfg_wen) begin
            unique case (lcdq_pkg::cfg_index_t'(cfg_index))
                lcdq_pkg::REG_FUNCTION_SET: function_set_reg <= cfg_wdata;
                lcdq_pkg::REG_DISPLAY_CTRL: display_ctrl_reg <= cfg_wdata;
                lcdq_pkg::REG_FIRST_LINE:   first_line_reg   <= cfg_wdata;
                lcdq_pkg::REG_SECOND_LINE:  second_line_reg  <= cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_phase_reg     <= INIT_START;
            write_phase_reg    <= WR_START;
            en_reg             <= 1'b0;
            rs_reg             <= 1'b0;
            data_reg           <= '0;
            busy_reg           <= 1'b1;
            request_active_reg <= 1'b0;
            current_slot_reg   <= '0;
            char_position_reg  <= '0;
            slot_pending_reg   <= '0;
            fill_slot_reg      <= '0;
            fill_active_reg    <= 1'b0;
            fill_len_reg       <= '0;
            m_valid_reg        <= 1'b0;
            rd_ok_reg          <= 1'b0;
        end else begin
            init_phase_reg     <= init_phase_next;
            write_phase_reg    <= write_phase_next;
            en_reg             <= en_next;
            rs_reg             <= rs_next;
            data_reg           <= data_next;
            busy_reg           <= busy_next;
            request_active_reg <= request_active_next;
            current_slot_reg   <= current_slot_next;
            char_position_reg  <= char_position_next;
            slot_pending_reg   <= slot_pending_next;
            fill_slot_reg      <= fill_slot_next;
            fill_active_reg    <= fill_active_next;
            fill_len_reg       <= fill_len_next;
            m_valid_reg        <= m_valid_next;
            rd_ok_reg          <= !back_fire;
        end
    end

    always_ff @(posedge aclk) begin
        slot_column_reg <= slot_column_next;
        slot_row_reg    <= slot_row_next;
        slot_length_reg <= slot_length_next;
        m_status_reg    <= m_status_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            text_mem[mem_waddr] <= q_item.character;
        end
        rd_data_reg <= text_mem[rd_addr];
    end

    // pins and busy only change when a request executes, which waits for the
    // result register to free up, so they double as the result payload
    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_enable_pin      = en_reg;
    assign m_register_select = rs_reg;
    assign m_data_bus        = data_reg;
    assign m_busy_res        = busy_reg;

`ifndef SYNTHESIS
    a_busy_in_init: assert property (@(posedge aclk) disable iff (!aresetn)
        (init_phase_reg != INIT_DONE) |-> busy_reg)
        else $error("busy low during initialization");

    a_fill_not_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_active_reg |-> !slot_pending_reg[fill_slot_reg])
        else $error("slot being filled is already pending");

    a_idle_write_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        !request_active_reg |-> (write_phase_reg == WR_START))
        else $error("write phase moved without an active request");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> ($stable(en_reg) && $stable(data_reg) && $stable(busy_reg)))
        else $error("pins changed while result was stalled");

    a_enable_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        en_reg |-> ((init_phase_reg != INIT_DONE) || request_active_reg))
        else $error("enable high with no sequence running");
`endif

endmodule

// ===== rtl/char_lcd_write_queue_sequencer.sv =====
// Top level of the character-LCD write queue sequencer.
`timescale 1ns / 1ps

// Character-LCD (8-bit bus) write sequencer.
// Input channel s_*: one request per item. s_operation 0 is a timing tick that
// advances the LCD pin sequence; 1 is one character of a string write, with
// s_column/s_row checked on the first character and s_is_last closing it.
// Result channel m_*: exactly one result per request, in order: a status code
// and the pin levels (enable, RS, RW, data bus) plus busy after that request.
// cfg_wen/cfg_index/cfg_wdata write the command bytes and line bases; write
// only while the block is idle.
// An accepted request is registered in the front-end queue, then executed by
// the back end into the result register; new requests are taken meanwhile.
// Throughput: one request per cycle while the receiver takes results, except
// a tick that puts a stored character on the bus, which waits for the
// registered read of the text memory (SLOTS*MAX_CHARS bytes) after the
// previous request.
// Reset starts the initialization sequence with busy high and the queue empty;
// no clearing pass is needed.
// When the receiver stalls, the result and pins are held, the back end stops,
// the two-entry queue fills and then s_ready drops.
module char_lcd_write_queue_sequencer #(
    parameter int SLOTS     = 4,
    parameter int MAX_CHARS = 16,
    parameter int COLUMNS   = 16,
    parameter int ROWS      = 2
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wen,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_operation,
    input  logic [7:0] s_character,
    input  logic [5:0] s_column,
    input  logic [1:0] s_row,
    input  logic       s_is_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_status,
    output logic       m_enable_pin,
    output logic       m_register_select,
    output logic       m_read_write,
    output logic [7:0] m_data_bus,
    output logic       m_busy_res
);

    logic              q_valid;
    logic              q_pop;
    lcdq_pkg::q_item_t q_item;

    lcdq_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_character (s_character),
        .s_column    (s_column),
        .s_row       (s_row),
        .s_is_last   (s_is_last),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop)
    );

    lcdq_back #(
        .SLOTS     (SLOTS),
        .MAX_CHARS (MAX_CHARS)
    ) u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wen           (cfg_wen),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .q_valid           (q_valid),
        .q_item            (q_item),
        .q_pop             (q_pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_enable_pin      (m_enable_pin),
        .m_register_select (m_register_select),
        .m_data_bus        (m_data_bus),
        .m_busy_res        (m_busy_res)
    );

    // write-only interface: RW stays low
    assign m_read_write = 1'b0;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the character-LCD write queue sequencer.
`timescale 1ns / 1ps

module testbench;

    localparam int SLOTS     = 4;
    localparam int MAX_CHARS = 16;
    localparam int COLUMNS   = 16;
    localparam int ROWS      = 2;
    localparam int LONG_HOLD = 120;

    localparam logic [2:0] INIT_BEGIN = 3'd0;
    localparam logic [2:0] INIT_DONE  = 3'd6;

    typedef enum logic [1:0] {
        STR_SELECT,
        STR_POSITION,
        STR_TEXT,
        STR_RETIRE
    } string_stage_t;

    typedef struct packed {
        lcdq_pkg::status_t status;
        logic              en;
        logic              rs;
        logic              rw;
        logic [7:0]        bus;
        logic              busy;
    } lcd_pins_t;

    // Tracks pin levels and string queue; holds expected results per request
    class lcd_scoreboard;
        logic [7:0]    fn_set_code, disp_ctrl_code, row0_base, row1_base;
        logic [2:0]    init_step;
        string_stage_t stage;
        bit            sending, filling;
        int            send_slot, fill_slot;
        logic [4:0]    char_idx;
        bit            pending [SLOTS];
        logic [7:0]    text [SLOTS][MAX_CHARS];
        logic [5:0]    start_col [SLOTS];
        bit            on_row1 [SLOTS];
        logic [4:0]    text_len [SLOTS];
        logic [7:0]    bus;
        bit            rs_pin, en_pin, busy;
        lcd_pins_t     expected_pins [$];
        int            mismatches, results_checked;
        int            n_ticks, n_chars, n_col_err, n_row_err, n_full, n_strings;

        function new();
            int i;
            fn_set_code    = lcdq_pkg::RST_FUNCTION_SET;
            disp_ctrl_code = lcdq_pkg::RST_DISPLAY_CTRL;
            row0_base      = lcdq_pkg::RST_FIRST_LINE;
            row1_base      = lcdq_pkg::RST_SECOND_LINE;
            init_step      = INIT_BEGIN;
            stage          = STR_SELECT;
            sending        = 0;
            filling        = 0;
            send_slot      = 0;
            fill_slot      = 0;
            char_idx       = '0;
            bus            = '0;
            rs_pin         = 0;
            en_pin         = 0;
            busy           = 1;
            for (i = 0; i < SLOTS; i++) begin
                pending[i] = 0;
            end
        endfunction

        function void write_reg(lcdq_pkg::cfg_index_t idx, logic [7:0] value);
            case (idx)
                lcdq_pkg::REG_FUNCTION_SET: fn_set_code    = value;
                lcdq_pkg::REG_DISPLAY_CTRL: disp_ctrl_code = value;
                lcdq_pkg::REG_FIRST_LINE:   row0_base      = value;
                lcdq_pkg::REG_SECOND_LINE:  row1_base      = value;
                default: ;
            endcase
        endfunction

        function void drive_byte(logic [7:0] value, bit is_data);
            bus    = value;
            rs_pin = is_data;
            en_pin = 1;
        endfunction

        function void drop_enable();
            en_pin = 0;
        endfunction

        function int lowest_pending();
            int i;
            lowest_pending = SLOTS;
            for (i = SLOTS - 1; i >= 0; i--) begin
                if (pending[i]) lowest_pending = i;
            end
        endfunction

        function void note_request(lcdq_pkg::item_kind_t op, logic [7:0] ch,
                                   logic [5:0] col, logic [1:0] row, logic last);
            lcdq_pkg::status_t st;
            int                i, s, nxt;
            logic [7:0]        cmd;
            logic [7:0]        pos_cmd;
            st = lcdq_pkg::STATUS_OK;
            if (op == lcdq_pkg::ITEM_CHAR) begin
                n_chars++;
                if (!filling) begin
                    if (col >= COLUMNS) begin
                        st = lcdq_pkg::STATUS_COLUMN;
                    end else if (row >= ROWS) begin
                        st = lcdq_pkg::STATUS_ROW;
                    end else begin
                        s = SLOTS;
                        for (i = SLOTS - 1; i >= 0; i--) begin
                            if (!pending[i]) s = i;
                        end
                        if (s == SLOTS) begin
                            st = lcdq_pkg::STATUS_FULL;
                        end else begin
                            fill_slot    = s;
                            filling      = 1;
                            start_col[s] = col;
                            on_row1[s]   = row[0];
                            text_len[s]  = '0;
                        end
                    end
                end
                case (st)
                    lcdq_pkg::STATUS_COLUMN: n_col_err++;
                    lcdq_pkg::STATUS_ROW:    n_row_err++;
                    lcdq_pkg::STATUS_FULL:   n_full++;
                    default: begin
                        // characters past the slot size are dropped silently
                        if (text_len[fill_slot] < MAX_CHARS) begin
                            text[fill_slot][text_len[fill_slot]] = ch;
                            text_len[fill_slot]++;
                        end
                        if (last) begin
                            pending[fill_slot] = 1;
                            filling = 0;
                            n_strings++;
                            if (!sending) begin
                                sending = 1;
                                stage   = STR_SELECT;
                            end
                        end
                    end
                endcase
            end else begin
                n_ticks++;
                if (init_step != INIT_DONE) begin
                    if (init_step == INIT_BEGIN) begin
                        drop_enable();
                        init_step = 3'd1;
                    end else begin
                        case (init_step)
                            3'd1:    cmd = fn_set_code;
                            3'd2:    cmd = lcdq_pkg::CMD_CLEAR;
                            3'd3:    cmd = lcdq_pkg::CMD_HOME;
                            3'd4:    cmd = disp_ctrl_code;
                            default: cmd = lcdq_pkg::CMD_DDRAM_START;
                        endcase
                        if (!en_pin) begin
                            drive_byte(cmd, 0);
                        end else begin
                            drop_enable();
                            init_step++;
                            if (init_step >= INIT_DONE) begin
                                init_step = INIT_DONE;
                                busy = 0;
                            end
                        end
                    end
                end else if (sending) begin
                    s = send_slot;
                    case (stage)
                        STR_SELECT: begin
                            nxt  = lowest_pending();
                            busy = 1;
                            if (nxt == SLOTS) begin
                                sending   = 0;
                                send_slot = 0;
                                busy      = 0;
                            end else begin
                                send_slot = nxt;
                                char_idx  = '0;
                                stage     = STR_POSITION;
                            end
                        end
                        STR_POSITION: begin
                            busy = 1;
                            if (!en_pin) begin
                                pos_cmd = (on_row1[s] ? row1_base : row0_base)
                                          + {2'b00, start_col[s]};
                                drive_byte(pos_cmd, 0);
                            end else begin
                                drop_enable();
                                stage = STR_TEXT;
                            end
                        end
                        STR_TEXT: begin
                            if (char_idx < text_len[s]) begin
                                if (!en_pin) begin
                                    drive_byte(text[s][char_idx], 1);
                                end else begin
                                    drop_enable();
                                    char_idx++;
                                end
                            end else begin
                                stage = STR_RETIRE;
                            end
                        end
                        default: begin
                            pending[s] = 0;
                            nxt = lowest_pending();
                            if (nxt == SLOTS) begin
                                sending   = 0;
                                send_slot = 0;
                                busy      = 0;
                            end else begin
                                send_slot = nxt;
                            end
                            stage = STR_SELECT;
                        end
                    endcase
                end
            end
            expected_pins.push_back('{st, en_pin, rs_pin, 1'b0, bus, busy});
        endfunction

        function void check_result(logic [1:0] status, logic en, logic rs, logic rw,
                                   logic [7:0] data, logic bsy);
            lcd_pins_t want;
            bit        bad;
            if (expected_pins.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: extra result st=%0d en=%b rs=%b rw=%b bus=%h busy=%b",
                             status, en, rs, rw, data, bsy);
                return;
            end
            want = expected_pins.pop_front();
            results_checked++;
            bad = (status !== want.status) || (en !== want.en) || (rs !== want.rs)
                  || (rw !== want.rw) || (data !== want.bus) || (bsy !== want.busy);
            if (bad) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: result %0d expected st=%0d en=%b rs=%b rw=%b bus=%h busy=%b",
                             results_checked, want.status, want.en, want.rs, want.rw,
                             want.bus, want.busy);
                    $display("       got st=%0d en=%b rs=%b rw=%b bus=%h busy=%b",
                             status, en, rs, rw, data, bsy);
                end
            end
        endfunction
    endclass

    logic       aclk;
    logic       aresetn;
    logic       cfg_wen;
    logic [1:0] cfg_index;
    logic [7:0] cfg_wdata;
    logic       s_valid;
    logic       s_ready;
    logic       s_operation;
    logic [7:0] s_character;
    logic [5:0] s_column;
    logic [1:0] s_row;
    logic       s_is_last;
    logic       m_valid;
    logic       m_ready;
    logic [1:0] m_status;
    logic       m_enable_pin;
    logic       m_register_select;
    logic       m_read_write;
    logic [7:0] m_data_bus;
    logic       m_busy_res;

    lcd_scoreboard sb;
    bit            idle_on;
    bit            long_hold_req;
    int            chars_left;
    logic [5:0]    str_col;
    logic [1:0]    str_row;

    char_lcd_write_queue_sequencer #(
        .SLOTS    (SLOTS),
        .MAX_CHARS(MAX_CHARS),
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS)
    ) u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wen          (cfg_wen),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_character      (s_character),
        .s_column         (s_column),
        .s_row            (s_row),
        .s_is_last        (s_is_last),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_enable_pin     (m_enable_pin),
        .m_register_select(m_register_select),
        .m_read_write     (m_read_write),
        .m_data_bus       (m_data_bus),
        .m_busy_res       (m_busy_res)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #4_000_000;
        $display("Timeout: results still outstanding or handshake stuck");
        $display("CHECKS FAILED");
        $finish;
    end

    // Result side: random stall bursts, plus one long hold on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                long_hold_req = 0;
                m_ready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 99) < 8) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready)
            sb.check_result(m_status, m_enable_pin, m_register_select, m_read_write,
                            m_data_bus, m_busy_res);
    end

    task automatic send_item(lcdq_pkg::item_kind_t op, logic [7:0] ch, logic [5:0] col,
                             logic [1:0] row, logic last);
        @(negedge aclk);
        if (idle_on && $urandom_range(0, 99) < 8) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_character <= ch;
        s_column    <= col;
        s_row       <= row;
        s_is_last   <= last;
        do @(posedge aclk); while (s_ready !== 1'b1);
        sb.note_request(op, ch, col, row, last);
    endtask

    task automatic send_tick();
        send_item(lcdq_pkg::ITEM_TICK, 8'($urandom), 6'($urandom), 2'($urandom),
                  1'($urandom));
    endtask

    task automatic cfg_write(lcdq_pkg::cfg_index_t idx, logic [7:0] value);
        @(negedge aclk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        sb.write_reg(idx, value);
    endtask

    task automatic program_regs(logic [7:0] fs, logic [7:0] dc, logic [7:0] b0,
                                logic [7:0] b1);
        cfg_write(lcdq_pkg::REG_FUNCTION_SET, fs);
        cfg_write(lcdq_pkg::REG_DISPLAY_CTRL, dc);
        cfg_write(lcdq_pkg::REG_FIRST_LINE, b0);
        cfg_write(lcdq_pkg::REG_SECOND_LINE, b1);
        @(negedge aclk);
        cfg_wen <= 1'b0;
    endtask

    // Close any open string, tick the queue empty, then wait for all results
    task automatic drain();
        while (sb.filling)
            send_item(lcdq_pkg::ITEM_CHAR, 8'($urandom), 6'($urandom), 2'($urandom), 1'b1);
        while (sb.sending || sb.init_step != INIT_DONE)
            send_tick();
        chars_left = 0;
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.expected_pins.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic run_random(int count, int hold_at);
        int         i;
        logic [5:0] col;
        logic [1:0] row;
        logic       last;
        for (i = 0; i < count; i++) begin
            if (i == hold_at) long_hold_req = 1;
            if ($urandom_range(0, 99) < 68) begin
                send_tick();
            end else begin
                if (chars_left == 0) begin
                    if ($urandom_range(0, 99) < 85) begin
                        str_col = 6'($urandom_range(0, COLUMNS - 1));
                        str_row = 2'($urandom_range(0, ROWS - 1));
                    end else begin
                        str_col = 6'($urandom);
                        str_row = 2'($urandom);
                    end
                    chars_left = ($urandom_range(0, 9) == 0)
                                 ? $urandom_range(MAX_CHARS + 1, MAX_CHARS + 4)
                                 : $urandom_range(1, MAX_CHARS);
                    col = str_col;
                    row = str_row;
                end else if ($urandom_range(0, 1)) begin
                    col = str_col;
                    row = str_row;
                end else begin
                    // ignored unless the first character was rejected
                    col = 6'($urandom);
                    row = 2'($urandom);
                end
                last = (chars_left == 1);
                if ($urandom_range(0, 99) < 3) last = ~last;
                chars_left = last ? 0 : chars_left - 1;
                send_item(lcdq_pkg::ITEM_CHAR, 8'($urandom), col, row, last);
            end
        end
    endtask

    initial begin
        sb            = new();
        idle_on       = 1;
        long_hold_req = 0;
        chars_left    = 0;
        aresetn       = 1'b0;
        cfg_wen       = 1'b0;
        cfg_index     = lcdq_pkg::REG_FUNCTION_SET;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_operation   = lcdq_pkg::ITEM_TICK;
        s_character   = '0;
        s_column      = '0;
        s_row         = '0;
        s_is_last     = 1'b0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        program_regs(8'hFF, 8'h00, 8'h00, 8'hFF);

        // strings queued while init is still running
        send_item(lcdq_pkg::ITEM_CHAR, 8'h00, 6'd0, 2'd0, 1'b0);
        send_item(lcdq_pkg::ITEM_CHAR, 8'hFF, 6'd63, 2'd3, 1'b1);
        // column is checked before row
        send_item(lcdq_pkg::ITEM_CHAR, 8'h41, 6'd16, 2'd0, 1'b1);
        send_item(lcdq_pkg::ITEM_CHAR, 8'h42, 6'd63, 2'd3, 1'b0);
        send_item(lcdq_pkg::ITEM_CHAR, 8'h43, 6'd0, 2'd2, 1'b0);
        send_item(lcdq_pkg::ITEM_CHAR, 8'h44, 6'd15, 2'd3, 1'b0);
        // after a reject the next character opens a fresh request
        send_item(lcdq_pkg::ITEM_CHAR, 8'h45, 6'd15, 2'd1, 1'b1);
        send_item(lcdq_pkg::ITEM_CHAR, 8'h46, 6'd7, 2'd1, 1'b1);
        send_item(lcdq_pkg::ITEM_CHAR, 8'h47, 6'd0, 2'd0, 1'b1);
        // all slots pending now
        send_item(lcdq_pkg::ITEM_CHAR, 8'h48, 6'd1, 2'd0, 1'b1);
        repeat (14) send_item(lcdq_pkg::ITEM_TICK, 8'h00, 6'd0, 2'd0, 1'b0);
        drain();

        run_random(240, 40);
        drain();
        program_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        run_random(240, -1);
        drain();
        program_regs(8'h00, 8'hFF, 8'hFF, 8'h00);
        run_random(240, -1);
        drain();
        program_regs(lcdq_pkg::RST_FUNCTION_SET, lcdq_pkg::RST_DISPLAY_CTRL,
                     lcdq_pkg::RST_FIRST_LINE, lcdq_pkg::RST_SECOND_LINE);
        idle_on = 0;
        run_random(240, -1);
        drain();
        repeat (10) @(posedge aclk);

        $display("Covered %0d requests: %0d ticks, %0d characters, %0d strings queued",
                 sb.n_ticks + sb.n_chars, sb.n_ticks, sb.n_chars, sb.n_strings);
        $display("Rejects: %0d column, %0d row, %0d no free slot; %0d results, %0d mismatches",
                 sb.n_col_err, sb.n_row_err, sb.n_full, sb.results_checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_pins.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
